FILE: rtl/core/mali_pkg.sv
// ----------------------------------------------------------------------------
// Motion activity package
// Shared widths, constants, sequencer states and control types for the
// motion activity leaky integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package mali_pkg;

    // Field and datapath widths
    localparam int POS_W   = 16;              // position, signed Q4.12
    localparam int MOVE_W  = POS_W + 1;       // movement, signed Q.12
    localparam int DIFF_W  = MOVE_W + 1;      // change of movement, signed Q.12
    localparam int MAG_W   = MOVE_W;          // magnitude of a change
    localparam int ACC_W   = 36;              // squared length, Q.24
    localparam int ROOT_W  = ACC_W / 2;       // square root, Q.12
    localparam int ACT_W   = 32;              // activity, unsigned Q20.12
    localparam int DECAY_W = 16;              // decay, unsigned Q0.16
    localparam int MUL_A_W = ACT_W;
    localparam int MUL_B_W = MAG_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CNT_W   = 5;

    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64225;
    localparam logic [ACT_W-1:0]   ACT_MAX     = {ACT_W{1'b1}};

    // Item kinds
    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_UPDATE = 1'b1;

    // Multiplier pass codes
    localparam logic [CNT_W-1:0] MUL_SQ_X  = 5'd0;
    localparam logic [CNT_W-1:0] MUL_SQ_Y  = 5'd1;
    localparam logic [CNT_W-1:0] MUL_SQ_Z  = 5'd2;
    localparam logic [CNT_W-1:0] MUL_DECAY = 5'd3;

    // Root pass: a load, then one step per result bit
    localparam logic [CNT_W-1:0]  ROOT_LAST      = CNT_W'(ROOT_W);
    localparam logic [ACC_W-1:0]  ROOT_FIRST_BIT = ACC_W'(1) << (ACC_W - 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_ROOT,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } sqrt_ctrl_t;

endpackage : mali_pkg

`default_nettype wire

FILE: rtl/core/mali_isqrt.sv
// ----------------------------------------------------------------------------
// Bit-serial integer square root
// Floor square root of a 36-bit radicand, one result bit per step,
// 18 steps after a load.
// ----------------------------------------------------------------------------
`default_nettype none

module mali_isqrt (
    input  wire logic                          aclk,
    input  wire mali_pkg::sqrt_ctrl_t          ctrl,
    input  wire logic [mali_pkg::ACC_W-1:0]    radicand,
    output logic      [mali_pkg::ROOT_W-1:0]   root
);

    logic [mali_pkg::ACC_W-1:0] rem_reg,  rem_next;
    logic [mali_pkg::ACC_W-1:0] res_reg,  res_next;
    logic [mali_pkg::ACC_W-1:0] bit_reg,  bit_next;
    logic [mali_pkg::ACC_W-1:0] trial;

    // Try to subtract the current trial value from the remainder
    always_comb begin
        trial    = res_reg + bit_reg;
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (ctrl.load) begin
            rem_next = radicand;
            res_next = '0;
            bit_next = mali_pkg::ROOT_FIRST_BIT;
        end else if (ctrl.step) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign root = res_reg[mali_pkg::ROOT_W-1:0];

endmodule : mali_isqrt

`default_nettype wire

FILE: rtl/core/motion_activity_leaky_integrator.sv
// ----------------------------------------------------------------------------
// Motion activity leaky integrator
// Integrates the magnitude of the change of movement of a tracked 3-D point
// with a programmable per-sample decay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transaction per position sample. s_kind = 0 starts
//   tracking (activity cleared), s_kind = 1 updates with a new position.
//   Result channel m_*: one transaction per input, carrying the activity
//   after that sample (unsigned Q20.12, saturating).
//   Config channel cfg_*: writes decay_factor (Q0.16); always ready, write
//   only while no sample is in flight.
// Sequence:
//   An update passes through one difference step, four passes of the
//   shared multiplier (three squares and the decay product), a load plus 18
//   steps of the bit-serial square root, a sum step and the output load;
//   a start sample goes from acceptance straight to the output load. The
//   root loop sets the rate; s_ready is high only while the sequencer is
//   idle, so a sample is not accepted until the previous one has reached
//   the output register.
// Reset and stall:
//   Reset clears position history, activity and the output, and restores the
//   default decay of 64225. A stalled result waits in the output register;
//   the next sample is still accepted, and its result holds until the slot
//   frees.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_activity_leaky_integrator (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic        [mali_pkg::DECAY_W-1:0]  cfg_data,
    // position samples
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_kind,
    input  wire logic signed [mali_pkg::POS_W-1:0]    s_pos_x,
    input  wire logic signed [mali_pkg::POS_W-1:0]    s_pos_y,
    input  wire logic signed [mali_pkg::POS_W-1:0]    s_pos_z,
    // activity results
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic             [mali_pkg::ACT_W-1:0]    m_activity
);

    // Movement from previous position, sign-extended
    function automatic logic [mali_pkg::MOVE_W-1:0] move_of(
        input logic [mali_pkg::POS_W-1:0] pos,
        input logic [mali_pkg::POS_W-1:0] last
    );
        move_of = {pos[mali_pkg::POS_W-1], pos} - {last[mali_pkg::POS_W-1], last};
    endfunction

    // Magnitude of the change between two movements
    function automatic logic [mali_pkg::MAG_W-1:0] mag_of(
        input logic [mali_pkg::MOVE_W-1:0] move,
        input logic [mali_pkg::MOVE_W-1:0] last
    );
        logic [mali_pkg::DIFF_W-1:0] d;
        logic [mali_pkg::DIFF_W-1:0] a;
        d = {move[mali_pkg::MOVE_W-1], move} - {last[mali_pkg::MOVE_W-1], last};
        a = d[mali_pkg::DIFF_W-1] ? (mali_pkg::DIFF_W'(0) - d) : d;
        mag_of = a[mali_pkg::MAG_W-1:0];
    endfunction

    mali_pkg::state_t state_reg, state_next;
    logic [mali_pkg::CNT_W-1:0]   cnt_reg, cnt_next;

    logic [mali_pkg::DECAY_W-1:0] decay_reg;
    logic [mali_pkg::POS_W-1:0]   in_x_reg, in_y_reg, in_z_reg;
    logic [mali_pkg::POS_W-1:0]   last_x_reg, last_y_reg, last_z_reg;
    logic [mali_pkg::MOVE_W-1:0]  last_move_x_reg, last_move_y_reg, last_move_z_reg;
    logic [mali_pkg::MOVE_W-1:0]  move_x, move_y, move_z;
    logic [mali_pkg::MAG_W-1:0]   mag_x_reg, mag_y_reg, mag_z_reg;
    logic [mali_pkg::ACT_W-1:0]   activity_reg;
    logic [mali_pkg::ACC_W-1:0]   acc_reg;
    logic [mali_pkg::PROD_W-1:0]  prod_reg;
    logic [mali_pkg::MUL_A_W-1:0] mul_a;
    logic [mali_pkg::MUL_B_W-1:0] mul_b;
    logic [mali_pkg::ROOT_W-1:0]  root;
    logic [mali_pkg::ACT_W:0]     sum;
    logic                         m_valid_reg;
    logic [mali_pkg::ACT_W-1:0]   m_activity_reg;
    logic                         s_accept;
    logic                         out_load;
    mali_pkg::sqrt_ctrl_t         sqrt_ctrl;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == mali_pkg::ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_activity = m_activity_reg;

    assign move_x = move_of(in_x_reg, last_x_reg);
    assign move_y = move_of(in_y_reg, last_y_reg);
    assign move_z = move_of(in_z_reg, last_z_reg);

    // Select the operands of the shared multiplier
    always_comb begin
        case (cnt_reg)
            mali_pkg::MUL_SQ_X: begin
                mul_a = mali_pkg::MUL_A_W'(mag_x_reg);
                mul_b = mag_x_reg;
            end
            mali_pkg::MUL_SQ_Y: begin
                mul_a = mali_pkg::MUL_A_W'(mag_y_reg);
                mul_b = mag_y_reg;
            end
            mali_pkg::MUL_SQ_Z: begin
                mul_a = mali_pkg::MUL_A_W'(mag_z_reg);
                mul_b = mag_z_reg;
            end
            default: begin
                mul_a = activity_reg;
                mul_b = mali_pkg::MUL_B_W'(decay_reg);
            end
        endcase
    end

    // Decayed activity plus root, one bit wider so that it can be saturated
    assign sum = {1'b0, prod_reg[mali_pkg::DECAY_W +: mali_pkg::ACT_W]}
               + (mali_pkg::ACT_W + 1)'(root);

    // Sequencer: next state, counter and unit controls
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sqrt_ctrl.load = 1'b0;
        sqrt_ctrl.step = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            mali_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_kind == mali_pkg::KIND_START) ? mali_pkg::ST_OUT
                                                                  : mali_pkg::ST_DIFF;
                end
            end
            mali_pkg::ST_DIFF: begin
                state_next = mali_pkg::ST_MUL;
                cnt_next   = mali_pkg::MUL_SQ_X;
            end
            mali_pkg::ST_MUL: begin
                if (cnt_reg == mali_pkg::MUL_DECAY) begin
                    state_next = mali_pkg::ST_ROOT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            mali_pkg::ST_ROOT: begin
                sqrt_ctrl.load = (cnt_reg == '0);
                sqrt_ctrl.step = (cnt_reg != '0);
                if (cnt_reg == mali_pkg::ROOT_LAST) begin
                    state_next = mali_pkg::ST_SUM;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            mali_pkg::ST_SUM: begin
                state_next = mali_pkg::ST_OUT;
            end
            mali_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = mali_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mali_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold sequencer, tracking state and output slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= mali_pkg::ST_IDLE;
            cnt_reg         <= '0;
            decay_reg       <= mali_pkg::DECAY_RESET;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            last_z_reg      <= '0;
            last_move_x_reg <= '0;
            last_move_y_reg <= '0;
            last_move_z_reg <= '0;
            activity_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                decay_reg <= cfg_data;
            end
            // start: load position, clear movement and activity
            if (s_accept && s_kind == mali_pkg::KIND_START) begin
                last_x_reg      <= s_pos_x;
                last_y_reg      <= s_pos_y;
                last_z_reg      <= s_pos_z;
                last_move_x_reg <= '0;
                last_move_y_reg <= '0;
                last_move_z_reg <= '0;
                activity_reg    <= '0;
            end
            // update: advance position history
            if (state_reg == mali_pkg::ST_DIFF) begin
                last_x_reg      <= in_x_reg;
                last_y_reg      <= in_y_reg;
                last_z_reg      <= in_z_reg;
                last_move_x_reg <= move_x;
                last_move_y_reg <= move_y;
                last_move_z_reg <= move_z;
            end
            if (state_reg == mali_pkg::ST_SUM) begin
                activity_reg <= sum[mali_pkg::ACT_W] ? mali_pkg::ACT_MAX
                                                     : sum[mali_pkg::ACT_W-1:0];
            end
            // output slot: fill on load, drop on handshake
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_x_reg <= s_pos_x;
            in_y_reg <= s_pos_y;
            in_z_reg <= s_pos_z;
        end
        if (state_reg == mali_pkg::ST_DIFF) begin
            mag_x_reg <= mag_of(move_x, last_move_x_reg);
            mag_y_reg <= mag_of(move_y, last_move_y_reg);
            mag_z_reg <= mag_of(move_z, last_move_z_reg);
        end
        // one product per cycle, accumulate the previous square
        if (state_reg == mali_pkg::ST_MUL) begin
            prod_reg <= mali_pkg::PROD_W'(mul_a) * mali_pkg::PROD_W'(mul_b);
            if (cnt_reg == mali_pkg::MUL_SQ_Y) begin
                acc_reg <= prod_reg[mali_pkg::ACC_W-1:0];
            end else if (cnt_reg != mali_pkg::MUL_SQ_X) begin
                acc_reg <= acc_reg + prod_reg[mali_pkg::ACC_W-1:0];
            end
        end
        if (out_load) begin
            m_activity_reg <= activity_reg;
        end
    end

    mali_isqrt u_isqrt (
        .aclk     (aclk),
        .ctrl     (sqrt_ctrl),
        .radicand (acc_reg),
        .root     (root)
    );

endmodule : motion_activity_leaky_integrator

`default_nettype wire

FILE: rtl/core/mali_checker.sv
// ----------------------------------------------------------------------------
// Motion activity port checker
// Port-level properties of the motion activity leaky integrator, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mali_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic                                s_kind,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic [mali_pkg::ACT_W-1:0]          m_activity
);

    // Result holds until taken
    a_m_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before handshake");

    // Stalled result keeps its value
    a_m_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_activity))
        else $error("result changed while stalled");

    // One sample at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second sample accepted while busy");

    // Start sample with an empty output slot yields zero activity
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == mali_pkg::KIND_START) && !m_valid
        |=> ##1 (m_valid && m_activity == '0))
        else $error("start sample did not report zero activity");

endmodule : mali_checker

bind motion_activity_leaky_integrator mali_checker u_mali_checker (.*);

`default_nettype wire

FILE: dv/tb_motion_activity_leaky_integrator.sv
// ----------------------------------------------------------------------------
// Testbench: motion activity leaky integrator
// Drives start and update position samples through the valid/ready input
// channel and checks each activity result against an in-bench tracker model
// or a typed table value. A short stimulus table covers the field extremes,
// the zero-motion and update-before-start cases and the decay extremes. A
// back-to-back run at full decay with alternating extreme positions drives
// the largest change of movement. Random tracks follow under several decay
// settings, with random idling on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_motion_activity_leaky_integrator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 6;
    localparam int IDLE_PCT    = 19;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYC    = 40;
    localparam int SWING_ITEMS = 40;
    localparam int SEG_ITEMS   = 140;
    localparam int NUM_SEGS    = 6;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_ROWS    = 23;

    // One row of the stimulus table: a decay write or a position sample
    typedef struct packed {
        logic                           is_cfg;
        logic                           kind;
        logic [mali_pkg::POS_W-1:0]     px;
        logic [mali_pkg::POS_W-1:0]     py;
        logic [mali_pkg::POS_W-1:0]     pz;
        logic [mali_pkg::DECAY_W-1:0]   decay;
        logic                           has_exp;
        logic [mali_pkg::ACT_W-1:0]     exp_act;
    } stim_row_t;

    localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
        // update straight out of reset: previous position and movement are zero
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h1000, 16'h0000, 16'h0000, 16'h0, 1'b1, 32'd4096},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h1000, 16'h0000, 16'h0000, 16'h0, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_START,  16'h0000, 16'h0000, 16'h0000, 16'h0, 1'b1, 32'd0},
        // no motion after a start
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h0000, 16'h0000, 16'h0000, 16'h0, 1'b1, 32'd0},
        '{1'b0, mali_pkg::KIND_START,  16'h8000, 16'h8000, 16'h8000, 16'h0, 1'b1, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h8000, 16'h8000, 16'h8000, 16'h0, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_START,  16'h5555, 16'hAAAA, 16'h00FF, 16'h0, 1'b1, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'hAAAA, 16'h5555, 16'hFF00, 16'h0, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 1'b0, 32'd0},
        // no decay: activity is the root alone
        '{1'b1, mali_pkg::KIND_START,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_START,  16'h0000, 16'h0000, 16'h0000, 16'h0, 1'b1, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h1000, 16'h0000, 16'h0000, 16'h0, 1'b1, 32'd4096},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h2000, 16'h0000, 16'h0000, 16'h0, 1'b1, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h2000, 16'h1000, 16'h0000, 16'h0, 1'b0, 32'd0},
        // full decay
        '{1'b1, mali_pkg::KIND_START,  16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_START,  16'h8000, 16'h8000, 16'h8000, 16'h0, 1'b1, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h8000, 16'h8000, 16'h8000, 16'h0, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h0000, 16'h0000, 16'h0000, 16'h0, 1'b0, 32'd0},
        '{1'b1, mali_pkg::KIND_START,  16'h0000, 16'h0000, 16'h0000,
          mali_pkg::DECAY_RESET, 1'b0, 32'd0},
        '{1'b0, mali_pkg::KIND_UPDATE, 16'h0064, 16'hFF9C, 16'h0007, 16'h0, 1'b0, 32'd0}
    };

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [mali_pkg::DECAY_W-1:0]       cfg_data  = '0;
    logic                               s_valid   = 1'b0;
    logic                               s_ready;
    logic                               s_kind    = mali_pkg::KIND_START;
    logic signed [mali_pkg::POS_W-1:0]  s_pos_x   = '0;
    logic signed [mali_pkg::POS_W-1:0]  s_pos_y   = '0;
    logic signed [mali_pkg::POS_W-1:0]  s_pos_z   = '0;
    logic                               m_valid;
    logic                               m_ready   = 1'b0;
    logic [mali_pkg::ACT_W-1:0]         m_activity;

    // Tracker model state
    logic signed [mali_pkg::POS_W-1:0]  trk_pos  [3];
    logic signed [mali_pkg::MOVE_W-1:0] trk_move [3];
    logic [mali_pkg::ACT_W-1:0]         trk_act;
    logic [mali_pkg::DECAY_W-1:0]       trk_decay;

    logic [mali_pkg::ACT_W-1:0]         act_expect_q [$];
    bit                                 idle_en = 1'b1;
    int                                 errors  = 0;
    int                                 stall_cnt = 0;

    motion_activity_leaky_integrator dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_pos_x    (s_pos_x),
        .s_pos_y    (s_pos_y),
        .s_pos_z    (s_pos_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_activity (m_activity)
    );

    always #CLK_HALF aclk = ~aclk;

    // Floor square root, one result bit per trial from the top down
    function automatic logic [mali_pkg::ROOT_W-1:0] floor_sqrt(longint unsigned v);
        logic [mali_pkg::ROOT_W-1:0] r;
        longint unsigned             t;
        r = '0;
        for (int b = mali_pkg::ROOT_W - 1; b >= 0; b--) begin
            t = 64'(r) | (64'd1 << b);
            if (t * t <= v) r = mali_pkg::ROOT_W'(t);
        end
        return r;
    endfunction

    // Advance the tracker by one sample and return the activity it reports
    function automatic logic [mali_pkg::ACT_W-1:0] track_sample(logic kind,
            logic signed [mali_pkg::POS_W-1:0] x, logic signed [mali_pkg::POS_W-1:0] y,
            logic signed [mali_pkg::POS_W-1:0] z);
        logic signed [mali_pkg::POS_W-1:0]  pnew [3];
        logic signed [mali_pkg::MOVE_W-1:0] mv;
        longint                             chg;
        longint unsigned                    len2;
        longint unsigned                    decayed;
        longint unsigned                    sum;
        pnew[0] = x;
        pnew[1] = y;
        pnew[2] = z;
        if (kind == mali_pkg::KIND_START) begin
            for (int a = 0; a < 3; a++) begin
                trk_pos[a]  = pnew[a];
                trk_move[a] = '0;
            end
            trk_act = '0;
        end else begin
            len2 = 0;
            for (int a = 0; a < 3; a++) begin
                mv          = pnew[a] - trk_pos[a];
                chg         = longint'(mv) - longint'(trk_move[a]);
                len2        = len2 + longint'(chg * chg);
                trk_move[a] = mv;
                trk_pos[a]  = pnew[a];
            end
            decayed = (64'(trk_act) * 64'(trk_decay)) >> mali_pkg::DECAY_W;
            sum     = decayed + 64'(floor_sqrt(len2));
            trk_act = (sum > 64'(mali_pkg::ACT_MAX)) ? mali_pkg::ACT_MAX
                                                     : mali_pkg::ACT_W'(sum);
        end
        return trk_act;
    endfunction

    // Present one sample, hold it until accepted, then record its activity.
    // Call from a rising-edge time step.
    task automatic push_sample(logic kind, logic [mali_pkg::POS_W-1:0] x,
            logic [mali_pkg::POS_W-1:0] y, logic [mali_pkg::POS_W-1:0] z,
            logic typed, logic [mali_pkg::ACT_W-1:0] typed_act);
        logic [mali_pkg::ACT_W-1:0] predicted;
        if (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(30, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        do @(posedge aclk); while (!s_ready);
        predicted = track_sample(kind, x, y, z);
        act_expect_q.push_back(typed ? typed_act : predicted);
    endtask

    // Drain every outstanding result, then write the decay register
    task automatic write_decay(logic [mali_pkg::DECAY_W-1:0] val);
        s_valid <= 1'b0;
        while (act_expect_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        trk_decay = val;
    endtask

    // Result side: random backpressure while idling is on, compare against the
    // oldest expectation, and watch for a hang
    always @(posedge aclk) begin
        logic [mali_pkg::ACT_W-1:0] want;
        m_ready <= idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        if (aresetn && m_valid && m_ready) begin
            if (act_expect_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, activity %0d", $realtime, m_activity);
            end else begin
                want = act_expect_q.pop_front();
                if (m_activity !== want) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: activity mismatch, expected %0d, got %0d",
                                 $realtime, want, m_activity);
                end
            end
        end
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [mali_pkg::POS_W-1:0]   p [3];
        logic [mali_pkg::DECAY_W-1:0] seg_decay [NUM_SEGS];
        logic                         kind;
        logic                         flip;
        int                           sent;
        int                           run_len;

        // Hold reset, starting the tracker from its reset state
        trk_decay = mali_pkg::DECAY_RESET;
        trk_act   = '0;
        for (int a = 0; a < 3; a++) begin
            trk_pos[a]  = '0;
            trk_move[a] = '0;
        end
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the stimulus table
        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].is_cfg)
                write_decay(DIR_ROWS[i].decay);
            else
                push_sample(DIR_ROWS[i].kind, DIR_ROWS[i].px, DIR_ROWS[i].py,
                            DIR_ROWS[i].pz, DIR_ROWS[i].has_exp, DIR_ROWS[i].exp_act);
        end

        // Full decay, positions swinging between the extremes so the change of
        // movement is as large as it gets; no idling on either side
        write_decay(16'hFFFF);
        idle_en = 1'b0;
        push_sample(mali_pkg::KIND_START, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0);
        flip = 1'b1;
        for (int i = 0; i < SWING_ITEMS; i++) begin
            p[0] = flip ? 16'h7FFF : 16'h8000;
            push_sample(mali_pkg::KIND_UPDATE, p[0], p[0], p[0], 1'b0, '0);
            flip = ~flip;
        end

        // Random tracks under several decay settings
        seg_decay = '{16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                      mali_pkg::DECAY_RESET};
        seg_decay[0] = mali_pkg::DECAY_W'($urandom_range(65535));
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            write_decay(seg_decay[seg]);
            idle_en = (seg != 2);
            sent = 0;
            while (sent < SEG_ITEMS) begin
                // mostly open a fresh track, now and then keep the old one going
                run_len = $urandom_range(12, 1);
                for (int i = 0; i <= run_len && sent < SEG_ITEMS; i++) begin
                    if (i == 0)
                        kind = ($urandom_range(99) >= 10) ? mali_pkg::KIND_START
                                                          : mali_pkg::KIND_UPDATE;
                    else
                        kind = ($urandom_range(99) < 3) ? mali_pkg::KIND_START
                                                        : mali_pkg::KIND_UPDATE;
                    for (int a = 0; a < 3; a++) begin
                        case ($urandom_range(5))
                            0, 1, 2: p[a] = trk_pos[a]
                                            + mali_pkg::POS_W'($urandom_range(1024))
                                            - mali_pkg::POS_W'(512);
                            3, 4:    p[a] = mali_pkg::POS_W'($urandom);
                            default: begin
                                case ($urandom_range(3))
                                    0:       p[a] = 16'h8000;
                                    1:       p[a] = 16'h7FFF;
                                    2:       p[a] = 16'h0000;
                                    default: p[a] = 16'hFFFF;
                                endcase
                            end
                        endcase
                    end
                    push_sample(kind, p[0], p[1], p[2], 1'b0, '0);
                    sent++;
                end
            end
        end

        // Drain, let the pipeline settle, then report
        s_valid <= 1'b0;
        idle_en = 1'b1;
        while (act_expect_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);
        if (act_expect_q.size() != 0) begin
            $display("%0d results never arrived", act_expect_q.size());
            errors++;
        end
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule : tb_motion_activity_leaky_integrator

`default_nettype wire
